>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/lsfl_pkg.sv
// Package: types, codes and constants of the linked stack block.
package lsfl_pkg;

    localparam int NODE_COUNT_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 4;
    localparam int CNT_SAT = 15;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_DEL_DEEP = 2'd2,
        OP_DEL_ALL  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   removed_count;
        logic [VAL_W-1:0]   top_value;
        logic               is_empty;
        logic [CNT_W-1:0]   entry_count;
    } t_result;

    typedef struct packed {
        logic rd_en;
        logic wr_value_en;
        logic wr_link_en;
    } t_mem_ctl;

    function automatic logic [CNT_W-1:0] sat_count(input logic [31:0] v);
        logic [CNT_W-1:0] r;
        if (v > 32'(CNT_SAT)) begin
            r = CNT_W'(CNT_SAT);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

>>> design/lsfl_if.sv
// Channel interfaces: command beats in, result beats out.
interface lsfl_in_if;
    logic                             valid;
    logic                             ready;
    logic [lsfl_pkg::OP_W-1:0]        operation;
    logic signed [lsfl_pkg::VAL_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface lsfl_out_if;
    logic                              valid;
    logic                              ready;
    logic [lsfl_pkg::STAT_W-1:0]       status;
    logic [lsfl_pkg::CNT_W-1:0]        removed_count;
    logic signed [lsfl_pkg::VAL_W-1:0] top_value;
    logic                              is_empty;
    logic [lsfl_pkg::CNT_W-1:0]        entry_count;

    modport source (output valid, output status, output removed_count, output top_value,
                    output is_empty, output entry_count, input ready);
    modport sink   (input valid, input status, input removed_count, input top_value,
                    input is_empty, input entry_count, output ready);
endinterface

>>> design/lsfl_store.sv
// Node store: value and link memories, one write and one registered read a cycle.
module lsfl_store #(
    parameter int NODE_COUNT  = lsfl_pkg::NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = lsfl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  lsfl_pkg::t_mem_ctl                 i_ctl,
    input  logic [$clog2(NODE_COUNT)-1:0]      i_rd_addr,
    input  logic [$clog2(NODE_COUNT)-1:0]      i_wr_addr,
    input  logic [VALUE_WIDTH-1:0]             i_wr_value,
    input  logic [$clog2(NODE_COUNT+1)-1:0]    i_wr_link,
    output logic [VALUE_WIDTH-1:0]             o_rd_value,
    output logic [$clog2(NODE_COUNT+1)-1:0]    o_rd_link
);
    localparam int LW = $clog2(NODE_COUNT + 1);

    logic [VALUE_WIDTH-1:0] r_values [NODE_COUNT];
    logic [LW-1:0]          r_links  [NODE_COUNT];
    logic [VALUE_WIDTH-1:0] r_rd_value;
    logic [LW-1:0]          r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_value_en) begin
            r_values[i_wr_addr] <= i_wr_value;
        end
        if (i_ctl.wr_link_en) begin
            r_links[i_wr_addr] <= i_wr_link;
        end
    end

    // hold read data until the next read strobe
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_value <= r_values[i_rd_addr];
            r_rd_link  <= r_links[i_rd_addr];
        end
    end

    assign o_rd_value = r_rd_value;
    assign o_rd_link  = r_rd_link;
endmodule

>>> design/lsfl_ctrl.sv
// Sequencer: walks the linked nodes with one shared compare and relinks them.
module lsfl_ctrl #(
    parameter int NODE_COUNT  = lsfl_pkg::NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = lsfl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lsfl_in_if.sink                            i_item,
    output lsfl_pkg::t_mem_ctl                 o_mem_ctl,
    output logic [$clog2(NODE_COUNT)-1:0]      o_rd_addr,
    output logic [$clog2(NODE_COUNT)-1:0]      o_wr_addr,
    output logic [VALUE_WIDTH-1:0]             o_wr_value,
    output logic [$clog2(NODE_COUNT+1)-1:0]    o_wr_link,
    input  logic [VALUE_WIDTH-1:0]             i_rd_value,
    input  logic [$clog2(NODE_COUNT+1)-1:0]    i_rd_link,
    output logic                               o_res_valid,
    output lsfl_pkg::t_result                  o_res,
    input  logic                               i_res_ready
);
    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam int VW = VALUE_WIDTH;
    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_START  = 9'b000000010,
        S_PUSHRD = 9'b000000100,
        S_POP    = 9'b000001000,
        S_WALK   = 9'b000010000,
        S_FIX    = 9'b000100000,
        S_FREE   = 9'b001000000,
        S_TOPRD  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    lsfl_pkg::t_op     r_op, n_op;
    lsfl_pkg::t_status r_status, n_status;
    logic [VW-1:0]     r_val, n_val;
    logic [LW-1:0]     r_top, n_top;
    logic [LW-1:0]     r_free, n_free;
    logic [LW-1:0]     r_fresh, n_fresh;
    logic [LW-1:0]     r_held, n_held;
    logic [LW-1:0]     r_removed, n_removed;
    logic [LW-1:0]     r_steps, n_steps;
    logic [LW-1:0]     r_prev, n_prev;
    logic [LW-1:0]     r_cur, n_cur;
    logic [LW-1:0]     r_nxt, n_nxt;
    logic [LW-1:0]     r_hit, n_hit;
    logic [LW-1:0]     r_hit_prev, n_hit_prev;
    logic [LW-1:0]     r_hit_next, n_hit_next;

    logic              match;
    logic [LW-1:0]     steps_inc;
    logic              walk_more;
    logic              free_more;
    logic [LW-1:0]     fresh_next;
    logic [LW-1:0]     held_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= NULL_LINK;
            r_free  <= LW'(NODE_COUNT - 1);
            r_fresh <= LW'(NODE_COUNT);
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_free  <= n_free;
            r_fresh <= n_fresh;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_status   <= n_status;
        r_val      <= n_val;
        r_removed  <= n_removed;
        r_steps    <= n_steps;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_hit      <= n_hit;
        r_hit_prev <= n_hit_prev;
        r_hit_next <= n_hit_next;
    end

    assign match      = (i_rd_value == r_val);
    assign steps_inc  = r_steps + LW'(1);
    assign walk_more  = (i_rd_link < NULL_LINK) && (steps_inc < NULL_LINK);
    assign free_more  = (r_nxt < NULL_LINK) && (r_steps < NULL_LINK);
    assign fresh_next = (r_free == '0) ? NULL_LINK : r_free - LW'(1);
    assign held_dec   = (r_held != '0) ? r_held - LW'(1) : r_held;

    assign i_item.ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);

    always_comb begin
        o_res.status        = r_status;
        o_res.removed_count = lsfl_pkg::sat_count(32'(r_removed));
        o_res.entry_count   = lsfl_pkg::sat_count(32'(r_held));
        o_res.is_empty      = (r_top == NULL_LINK);
        o_res.top_value     = (r_top == NULL_LINK) ? '0 : lsfl_pkg::VAL_W'(i_rd_value);
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_status   = r_status;
        n_val      = r_val;
        n_top      = r_top;
        n_free     = r_free;
        n_fresh    = r_fresh;
        n_held     = r_held;
        n_removed  = r_removed;
        n_steps    = r_steps;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_nxt      = r_nxt;
        n_hit      = r_hit;
        n_hit_prev = r_hit_prev;
        n_hit_next = r_hit_next;
        o_mem_ctl  = '0;
        o_rd_addr  = '0;
        o_wr_addr  = '0;
        o_wr_value = r_val;
        o_wr_link  = r_top;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_op    = lsfl_pkg::t_op'(i_item.operation);
                    n_val   = VW'($unsigned(i_item.value));
                    n_state = S_START;
                end
            end
            S_START: begin
                n_removed = '0;
                n_status  = lsfl_pkg::ST_DONE;
                if (r_op == lsfl_pkg::OP_PUSH) begin
                    if (r_free == NULL_LINK) begin
                        n_status = lsfl_pkg::ST_FULL;
                        n_state  = S_TOPRD;
                    end else if (r_free < r_fresh) begin
                        // untouched node: its free link is implied
                        n_fresh               = r_free;
                        n_free                = fresh_next;
                        o_mem_ctl.wr_value_en = 1'b1;
                        o_mem_ctl.wr_link_en  = 1'b1;
                        o_wr_addr             = r_free[AW-1:0];
                        n_top                 = r_free;
                        n_held                = r_held + LW'(1);
                        n_state               = S_TOPRD;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = r_free[AW-1:0];
                        n_state         = S_PUSHRD;
                    end
                end else if (r_top == NULL_LINK) begin
                    n_status = lsfl_pkg::ST_EMPTY;
                    n_state  = S_TOPRD;
                end else if (r_op == lsfl_pkg::OP_POP) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = r_top[AW-1:0];
                    n_state         = S_POP;
                end else begin
                    n_status        = lsfl_pkg::ST_NOMATCH;
                    n_prev          = NULL_LINK;
                    n_cur           = r_top;
                    n_hit           = NULL_LINK;
                    n_steps         = '0;
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = r_top[AW-1:0];
                    n_state         = S_WALK;
                end
            end
            S_PUSHRD: begin
                n_free                = i_rd_link;
                o_mem_ctl.wr_value_en = 1'b1;
                o_mem_ctl.wr_link_en  = 1'b1;
                o_wr_addr             = r_free[AW-1:0];
                n_top                 = r_free;
                n_held                = r_held + LW'(1);
                n_state               = S_TOPRD;
            end
            S_POP: begin
                n_top                = i_rd_link;
                o_mem_ctl.wr_link_en = 1'b1;
                o_wr_addr            = r_top[AW-1:0];
                o_wr_link            = r_free;
                n_free               = r_top;
                n_held               = held_dec;
                n_removed            = LW'(1);
                n_state              = S_TOPRD;
            end
            S_WALK: begin
                n_steps = steps_inc;
                n_nxt   = i_rd_link;
                if (r_op == lsfl_pkg::OP_DEL_DEEP) begin
                    // keep the last hit: it is the deepest one
                    if (match) begin
                        n_hit      = r_cur;
                        n_hit_prev = r_prev;
                        n_hit_next = i_rd_link;
                    end
                    n_prev = r_cur;
                    n_cur  = i_rd_link;
                    if (walk_more) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = i_rd_link[AW-1:0];
                    end else begin
                        n_state = S_FIX;
                    end
                end else if (match) begin
                    // unlink here, return the node to the free list next cycle
                    if (r_prev != NULL_LINK) begin
                        o_mem_ctl.wr_link_en = 1'b1;
                        o_wr_addr            = r_prev[AW-1:0];
                        o_wr_link            = i_rd_link;
                    end else begin
                        n_top = i_rd_link;
                    end
                    n_state = S_FREE;
                end else begin
                    n_prev = r_cur;
                    n_cur  = i_rd_link;
                    if (walk_more) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = i_rd_link[AW-1:0];
                    end else begin
                        n_state = S_TOPRD;
                    end
                end
            end
            S_FIX: begin
                if (r_hit == NULL_LINK) begin
                    n_state = S_TOPRD;
                end else begin
                    if (r_hit_prev != NULL_LINK) begin
                        o_mem_ctl.wr_link_en = 1'b1;
                        o_wr_addr            = r_hit_prev[AW-1:0];
                        o_wr_link            = r_hit_next;
                    end else begin
                        n_top = r_hit_next;
                    end
                    n_cur   = r_hit;
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                o_mem_ctl.wr_link_en = 1'b1;
                o_wr_addr            = r_cur[AW-1:0];
                o_wr_link            = r_free;
                n_free               = r_cur;
                n_held               = held_dec;
                n_removed            = r_removed + LW'(1);
                n_status             = lsfl_pkg::ST_DONE;
                if (r_op == lsfl_pkg::OP_DEL_DEEP) begin
                    n_state = S_TOPRD;
                end else begin
                    n_cur = r_nxt;
                    if (free_more) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = r_nxt[AW-1:0];
                        n_state         = S_WALK;
                    end else begin
                        n_state = S_TOPRD;
                    end
                end
            end
            S_TOPRD: begin
                if (r_top != NULL_LINK) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = r_top[AW-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> design/linked_stack_with_free_list_top.sv
// One item at a time: the next item is taken only after the result has moved into the
// output register. The node store's single read port sets the walk rate: one node per
// cycle, and each node freed by a delete adds a free step. Reset is synchronous, active
// low, and the block takes items on the next cycle: untouched nodes form the free tail,
// so no clearing pass.
module linked_stack_with_free_list_top #(
    parameter int NODE_COUNT  = lsfl_pkg::NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = lsfl_pkg::VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsfl_in_if.sink    i_item,
    lsfl_out_if.source o_result
);
    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);

    // memory request and read-back between sequencer and node store
    lsfl_pkg::t_mem_ctl     mem_ctl;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_value;
    logic [LW-1:0]          wr_link;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [LW-1:0]          rd_link;

    // finished result from the sequencer
    logic                   res_valid;
    lsfl_pkg::t_result      res;
    logic                   slot_free;

    // output register: parts the sequencer from the result consumer
    logic                   r_out_valid;
    lsfl_pkg::t_result      r_out;

    lsfl_ctrl #(
        .NODE_COUNT  (NODE_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_mem_ctl   (mem_ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_value  (wr_value),
        .o_wr_link   (wr_link),
        .i_rd_value  (rd_value),
        .i_rd_link   (rd_link),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (slot_free)
    );

    lsfl_store #(
        .NODE_COUNT  (NODE_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (mem_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_value (wr_value),
        .i_wr_link  (wr_link),
        .o_rd_value (rd_value),
        .o_rd_link  (rd_link)
    );

    // the slot takes a new result when empty or when its beat leaves this cycle
    assign slot_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
    end

    // hold the payload while the beat is stalled
    always_ff @(posedge i_clk) begin
        if (slot_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out.status;
    assign o_result.removed_count = r_out.removed_count;
    assign o_result.top_value     = r_out.top_value;
    assign o_result.is_empty      = r_out.is_empty;
    assign o_result.entry_count   = r_out.entry_count;
endmodule

>>> design/lsfl_chk.sv
// Port checker for the linked stack block and its bind to the top level.
`include "assert_macros.svh"

module lsfl_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [lsfl_pkg::STAT_W-1:0]       i_status,
    input logic [lsfl_pkg::CNT_W-1:0]        i_removed,
    input logic [lsfl_pkg::VAL_W-1:0]        i_top,
    input logic                              i_empty,
    input logic [lsfl_pkg::CNT_W-1:0]        i_count
);
    logic [lsfl_pkg::STAT_W+2*lsfl_pkg::CNT_W+lsfl_pkg::VAL_W:0] payload;
    logic                                                         refused;

    assign payload = {i_status, i_removed, i_top, i_empty, i_count};
    assign refused = (i_status != lsfl_pkg::ST_DONE);

    // a stalled result beat holds
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(payload))

    // one item at a time: ready drops after each accepted beat
    `AST_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // empty flag agrees with the entry count
    `AST_IMPL(a_empty_cnt, i_clk, i_rst_n, i_out_valid, i_empty == (i_count == '0))

    // an empty stack reports a zero top
    `AST_IMPL(a_empty_top, i_clk, i_rst_n, i_out_valid && i_empty, i_top == '0)

    // a refused or missed operation removes nothing
    `AST_IMPL(a_fail_none, i_clk, i_rst_n, i_out_valid && refused, i_removed == '0)
endmodule

bind linked_stack_with_free_list_top lsfl_chk u_lsfl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.status),
    .i_removed   (o_result.removed_count),
    .i_top       (o_result.top_value),
    .i_empty     (o_result.is_empty),
    .i_count     (o_result.entry_count)
);
